@@ rtl/core/lot_pkg.sv @@
// ----------------------------------------------------------------------------
// Lock ownership tracker package
// Widths, event and status codes, table entry record and shared helpers.
// ----------------------------------------------------------------------------
package lot_pkg;

    localparam int ENTRIES    = 64;
    localparam int COUNT_W    = 16;
    localparam int KEY_W      = 48;
    localparam int THREAD_W   = 32;
    localparam int OUT_CNT_W  = 16;
    localparam int KIND_W     = 3;
    localparam int STATUS_W   = 3;

    localparam logic [COUNT_W-1:0]   CNT_MAX     = '1;
    localparam logic [OUT_CNT_W-1:0] OUT_CNT_MAX = '1;

    // Event kinds; the codes above destroy carry no meaning.
    typedef enum logic [KIND_W-1:0] {
        REQ_CREATE  = 3'd0,
        REQ_OBTAIN  = 3'd1,
        REQ_ABANDON = 3'd2,
        REQ_RELEASE = 3'd3,
        REQ_DESTROY = 3'd4
    } req_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK            = 3'd0,
        STAT_OTHER_OBTAIN  = 3'd1,
        STAT_HOLDER_ABAND  = 3'd2,
        STAT_SURPLUS_REL   = 3'd3,
        STAT_NONOWNER_REL  = 3'd4,
        STAT_DESTROY_HELD  = 3'd5,
        STAT_TABLE_FULL    = 3'd6
    } status_t;

    // One lock entry, everything but the key and the valid bit.
    typedef struct packed {
        logic [THREAD_W-1:0] owner;
        logic [THREAD_W-1:0] creator;
        logic [THREAD_W-1:0] releaser;
        logic [THREAD_W-1:0] aband_owner;
        logic [COUNT_W-1:0]  depth;
        logic [COUNT_W-1:0]  aband_cnt;
        logic [COUNT_W-1:0]  surplus_cnt;
        logic                held;
        logic                excl;
    } entry_t;

    // Lookup result handed from the match logic to the update logic.
    typedef struct packed {
        logic               hit;
        logic [ENTRIES-1:0] hit_oh;
        logic               free_ok;
        logic [ENTRIES-1:0] free_oh;
    } lookup_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + COUNT_W'(1);
    endfunction

    // Counts are shown clipped to the result field width.
    function automatic logic [OUT_CNT_W-1:0] clip_out(input logic [COUNT_W-1:0] v);
        logic [OUT_CNT_W-1:0] r;
        r = OUT_CNT_W'(v);
        if (COUNT_W > OUT_CNT_W)
        begin
            if ((v >> OUT_CNT_W) != '0)
            begin
                r = OUT_CNT_MAX;
            end
        end
        clip_out = r;
    endfunction

endpackage

@@ rtl/core/lot_req_if.sv @@
// ----------------------------------------------------------------------------
// Lock event channel
// Valid/ready channel carrying one lock event per transaction.
// ----------------------------------------------------------------------------
interface lot_req_if;
    logic                          valid;
    logic                          ready;
    logic [lot_pkg::KIND_W-1:0]    req_type;
    logic [lot_pkg::KEY_W-1:0]     lock_id;
    logic [lot_pkg::THREAD_W-1:0]  thread_id;

    modport source (output valid, req_type, lock_id, thread_id, input ready);
    modport sink   (input valid, req_type, lock_id, thread_id, output ready);
endinterface

@@ rtl/core/lot_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Lock result channel
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
interface lot_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [lot_pkg::STATUS_W-1:0]   status;
    logic                           is_locked;
    logic [lot_pkg::THREAD_W-1:0]   owner_thread;
    logic [lot_pkg::OUT_CNT_W-1:0]  depth;
    logic [lot_pkg::OUT_CNT_W-1:0]  abandon_total;
    logic [lot_pkg::OUT_CNT_W-1:0]  surplus_total;

    modport source (output valid, status, is_locked, owner_thread, depth,
                    abandon_total, surplus_total, input ready);
    modport sink   (input valid, status, is_locked, owner_thread, depth,
                    abandon_total, surplus_total, output ready);
endinterface

@@ rtl/core/lot_lookup.sv @@
// ----------------------------------------------------------------------------
// Lock table lookup
// Parallel key compare over all entries and lowest free entry search.
// ----------------------------------------------------------------------------
module lot_lookup (
    input  logic [lot_pkg::KEY_W-1:0]   key,
    input  logic [lot_pkg::ENTRIES-1:0] valid_vec,
    input  logic [lot_pkg::KEY_W-1:0]   keys [lot_pkg::ENTRIES],
    output lot_pkg::lookup_t            result
);
    import lot_pkg::*;

    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] free_vec;

    // Compare the key against every valid entry at once.
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_vec[i] = valid_vec[i] && (keys[i] == key);
        end
    end

    assign free_vec = ~valid_vec;

    // Isolate the lowest set bit of each vector.
    always_comb
    begin
        result.hit     = |match_vec;
        result.hit_oh  = match_vec & (~match_vec + ENTRIES'(1));
        result.free_ok = |free_vec;
        result.free_oh = free_vec & (~free_vec + ENTRIES'(1));
    end

endmodule

@@ rtl/core/lock_ownership_tracker_core.sv @@
// ----------------------------------------------------------------------------
// Lock ownership tracker
// Tracks owner, recursion depth and misuse counts of up to ENTRIES locks in a
// fully associative table and answers each lock event with a status.
//
//   Channel | Role   | Payload
//   --------+--------+-----------------------------------------------------
//   req     | sink   | req_type, lock_id, thread_id
//   rsp     | source | status, is_locked, owner_thread, depth,
//           |        | abandon_total, surplus_total
//
// One transaction per cycle is sustained while rsp.ready is high; an accepted
// event passes through the input register, then the result register, and
// its result is held there until rsp.ready takes it.
// The key compare, the update of the chosen entry and the table write all
// happen in the cycle the event moves from the input to the result register.
// Reset clears the entry valid bits at once; no clearing pass is needed.
// A stalled result holds the input register, and req.ready drops only while
// both registers are full and rsp.ready is low.
// ----------------------------------------------------------------------------
module lock_ownership_tracker_core (
    input  logic       clk,
    input  logic       rst_n,
    lot_req_if.sink    req,
    lot_rsp_if.source  rsp
);
    import lot_pkg::*;

    // Input register
    logic                a_valid_reg;
    logic [KIND_W-1:0]   a_kind_reg;
    logic [KEY_W-1:0]    a_key_reg;
    logic [THREAD_W-1:0] a_thread_reg;

    // Result register
    logic                 r_valid_reg;
    status_t              r_status_reg;
    logic                 r_locked_reg;
    logic [THREAD_W-1:0]  r_owner_reg;
    logic [OUT_CNT_W-1:0] r_depth_reg;
    logic [OUT_CNT_W-1:0] r_aband_reg;
    logic [OUT_CNT_W-1:0] r_surplus_reg;

    // Lock table
    logic [ENTRIES-1:0] valid_reg;
    logic [KEY_W-1:0]   key_reg   [ENTRIES];
    entry_t             entry_reg [ENTRIES];

    lookup_t            look;
    logic               a_fire;
    logic               r_load;
    logic               known_kind;
    logic               have_entry;
    logic               free_entry;
    logic               zero_result;
    logic [ENTRIES-1:0] target_oh;
    entry_t             cur;
    entry_t             nxt;
    status_t            status;

    // Pipeline handshake
    assign r_load    = a_valid_reg && (!r_valid_reg || rsp.ready);
    assign req.ready = !a_valid_reg || r_load;
    assign a_fire    = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            a_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_fire)
        begin
            a_kind_reg   <= req.req_type;
            a_key_reg    <= req.lock_id;
            a_thread_reg <= req.thread_id;
        end
    end

    // Key match and free entry search
    lot_lookup u_lookup (
        .key       (a_key_reg),
        .valid_vec (valid_reg),
        .keys      (key_reg),
        .result    (look)
    );

    // Read the hit entry through a one-hot select; a new entry reads as clear.
    always_comb
    begin
        logic [$bits(entry_t)-1:0] acc;
        acc = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            acc = acc | (entry_reg[i] & {$bits(entry_t){look.hit_oh[i]}});
        end
        cur = look.hit ? entry_t'(acc) : '0;
    end

    assign known_kind = (a_kind_reg == REQ_CREATE)  || (a_kind_reg == REQ_OBTAIN) ||
                        (a_kind_reg == REQ_ABANDON) || (a_kind_reg == REQ_RELEASE) ||
                        (a_kind_reg == REQ_DESTROY);
    assign have_entry = known_kind &&
                        (look.hit || ((a_kind_reg != REQ_DESTROY) && look.free_ok));
    assign target_oh  = look.hit ? look.hit_oh : look.free_oh;

    // Event update of the selected entry
    always_comb
    begin
        nxt        = cur;
        status     = STAT_OK;
        free_entry = 1'b0;
        case (a_kind_reg)
            REQ_CREATE:
            begin
                nxt.creator = a_thread_reg;
                nxt.held    = 1'b0;
                nxt.excl    = 1'b0;
            end
            REQ_OBTAIN:
            begin
                if (cur.held && (cur.owner != a_thread_reg))
                begin
                    status = STAT_OTHER_OBTAIN;
                end
                else
                begin
                    if (cur.held)
                    begin
                        nxt.depth = sat_inc(cur.depth);
                    end
                    nxt.owner = a_thread_reg;
                    nxt.held  = 1'b1;
                    nxt.excl  = 1'b1;
                end
            end
            REQ_ABANDON:
            begin
                if (cur.held && (cur.owner == a_thread_reg))
                begin
                    status = STAT_HOLDER_ABAND;
                end
                else
                begin
                    if (cur.held)
                    begin
                        nxt.aband_cnt   = sat_inc(cur.aband_cnt);
                        nxt.aband_owner = cur.owner;
                        nxt.depth       = '0;
                    end
                    nxt.owner = a_thread_reg;
                    nxt.held  = 1'b1;
                    nxt.excl  = 1'b1;
                end
            end
            REQ_RELEASE:
            begin
                if (!cur.held || !cur.excl)
                begin
                    // A surplus release still counts.
                    nxt.surplus_cnt = sat_inc(cur.surplus_cnt);
                    status          = STAT_SURPLUS_REL;
                end
                else if (cur.owner != a_thread_reg)
                begin
                    status = STAT_NONOWNER_REL;
                end
                else
                begin
                    nxt.releaser = a_thread_reg;
                    if (cur.depth != '0)
                    begin
                        nxt.depth = cur.depth - COUNT_W'(1);
                    end
                    else
                    begin
                        nxt.held = 1'b0;
                        nxt.excl = 1'b0;
                    end
                end
            end
            REQ_DESTROY:
            begin
                if (cur.held && (cur.owner != a_thread_reg))
                begin
                    status = STAT_DESTROY_HELD;
                end
                else
                begin
                    free_entry = 1'b1;
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
        if (known_kind && !have_entry && (a_kind_reg != REQ_DESTROY))
        begin
            status = STAT_TABLE_FULL;
        end
    end

    assign zero_result = !have_entry || free_entry;

    // Table write when the event moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (r_load && have_entry)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (target_oh[i])
                begin
                    valid_reg[i] <= !free_entry;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (r_load && have_entry)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (target_oh[i])
                begin
                    key_reg[i]   <= a_key_reg;
                    entry_reg[i] <= nxt;
                end
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
        end
        else if (!r_valid_reg || rsp.ready)
        begin
            r_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (r_load)
        begin
            r_status_reg  <= zero_result ? ((known_kind && !have_entry) ? status : STAT_OK)
                                         : status;
            r_locked_reg  <= zero_result ? 1'b0 : nxt.held;
            r_owner_reg   <= zero_result ? '0 : nxt.owner;
            r_depth_reg   <= zero_result ? '0 : clip_out(nxt.depth);
            r_aband_reg   <= zero_result ? '0 : clip_out(nxt.aband_cnt);
            r_surplus_reg <= zero_result ? '0 : clip_out(nxt.surplus_cnt);
        end
    end

    assign rsp.valid         = r_valid_reg;
    assign rsp.status        = r_status_reg;
    assign rsp.is_locked     = r_locked_reg;
    assign rsp.owner_thread  = r_owner_reg;
    assign rsp.depth         = r_depth_reg;
    assign rsp.abandon_total = r_aband_reg;
    assign rsp.surplus_total = r_surplus_reg;

    // An event in the input register reaches an empty result register next cycle.
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !r_valid_reg) |=> r_valid_reg)
        else $error("event did not advance to the result register");

    // A full table is reported only when no entry is free.
    a_full_real: assert property (@(posedge clk) disable iff (!rst_n)
        (r_load && (status == STAT_TABLE_FULL)) |-> (&valid_reg))
        else $error("table full reported with a free entry");

    // Allocation takes exactly one more entry.
    a_alloc_count: assert property (@(posedge clk) disable iff (!rst_n)
        (r_load && have_entry && !look.hit) |=>
        ($countones(valid_reg) == $countones($past(valid_reg)) + 1))
        else $error("allocation did not take one entry");

    // A successful destroy frees exactly one entry.
    a_free_count: assert property (@(posedge clk) disable iff (!rst_n)
        (r_load && have_entry && free_entry) |=>
        ($countones(valid_reg) + 1 == $countones($past(valid_reg))))
        else $error("destroy did not free one entry");

endmodule
